FILE: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median filter
// Defaults for the window and sample widths, the configuration register
// layout and the control group that drives the row of sorting cells.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;
    localparam int WINDOW_RESET    = 64;
    localparam int MIN_WINDOW      = 2;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctl_t;

endpackage

FILE: src/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median: running median over a sliding window of samples
// Keeps the last window_size samples in a sorted row of cells and returns
// twice the window median for every sample once the window has filled.
// ----------------------------------------------------------------------------
// One sample is accepted per clock cycle while the input is not stalled:
// the whole cell row removes the oldest sample and inserts the new one in
// one register update, and the median is read from the row into the output
// register once it is free. One result can wait in a pending stage while
// the output is stalled; input stalls only when both that stage and the
// output register are full. No result is given until window_size samples
// have arrived since reset, a restart flag (tuser) or a write of window_size.
// window_size below 2 acts as 2 and above MAX_WINDOW acts as MAX_WINDOW.
module sliding_window_median #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]                    cfg_wdata,  // window_size
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]             s_axis_tdata,  // sample
    input  logic [0:0]                                   s_axis_tuser,  // restart
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]             m_axis_tdata   // median_doubled
);

    import swm_pkg::*;

    localparam int AGE_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int OUT_W     = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int CMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
    localparam int WIN_RST   = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic [CNT_W-1:0]       w_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic                   pend_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS:0]   out_data_reg;

    logic [CMP_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       cfg_clamped;
    logic                   accept;
    logic                   out_free;
    logic                   restart;
    logic [CNT_W-1:0]       fill_base;
    logic                   full;
    logic                   result;
    logic [CNT_W-1:0]       fill_next;
    cell_ctl_t              ctl;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] q_value [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         q_valid;
    logic [AGE_W-1:0]              q_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         vld_eff;
    logic [MAX_WINDOW-1:0]         rm_vec;
    logic [MAX_WINDOW-1:0]         r_le;
    logic [AGE_W-1:0]              oldest_age;
    logic signed [SAMPLE_BITS:0]   median;

    assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign restart  = s_axis_tuser[0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // window size clamp
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_wdata);
        if (cfg_ext < CMP_W'(MIN_WINDOW))
        begin
            cfg_clamped = CNT_W'(MIN_WINDOW);
        end
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
        begin
            cfg_clamped = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_clamped = cfg_ext[CNT_W-1:0];
        end
    end

    always_comb
    begin
        fill_base = restart ? '0 : fill_reg;
        full      = (fill_base == w_reg);
        result    = full || ((fill_base + CNT_W'(1)) == w_reg);
        fill_next = full ? fill_base : fill_base + CNT_W'(1);
        ctl.load  = accept;
        ctl.clear = cfg_we;
    end

    // oldest sample leaves the row once the window is full
    assign oldest_age = AGE_W'(w_reg - CNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            vld_eff[i] = q_valid[i] && !restart;
            rm_vec[i]  = full && vld_eff[i] && (q_age[i] == oldest_age);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_row
            logic signed [SAMPLE_BITS-1:0] dn_value;
            logic                          dn_valid;
            logic [AGE_W-1:0]              dn_age;
            logic signed [SAMPLE_BITS-1:0] up_value;
            logic                          up_valid;
            logic [AGE_W-1:0]              up_age;
            logic                          shift_prev;

            assign r_le[g] = |rm_vec[g:0];

            if (g == 0)
            begin : g_bottom
                assign dn_value   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                assign dn_valid   = 1'b1;
                assign dn_age     = '0;
                assign shift_prev = 1'b0;
            end
            else
            begin : g_mid_dn
                assign dn_value   = q_value[g-1];
                assign dn_valid   = vld_eff[g-1];
                assign dn_age     = q_age[g-1];
                assign shift_prev = r_le[g-1];
            end

            if (g == MAX_WINDOW - 1)
            begin : g_top
                assign up_value = '0;
                assign up_valid = 1'b0;
                assign up_age   = '0;
            end
            else
            begin : g_mid_up
                assign up_value = q_value[g+1];
                assign up_valid = vld_eff[g+1];
                assign up_age   = q_age[g+1];
            end

            swm_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .AGE_W      (AGE_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .sample    (sample),
                .dn_value  (dn_value),
                .dn_valid  (dn_valid),
                .dn_age    (dn_age),
                .self_valid(vld_eff[g]),
                .up_value  (up_value),
                .up_valid  (up_valid),
                .up_age    (up_age),
                .shift_prev(shift_prev),
                .shift_here(r_le[g]),
                .value     (q_value[g]),
                .valid     (q_valid[g]),
                .age       (q_age[g])
            );
        end
    endgenerate

    swm_median #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS),
        .AGE_W      (AGE_W),
        .CNT_W      (CNT_W)
    ) u_median (
        .values(q_value),
        .window(w_reg),
        .median(median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= CNT_W'(WIN_RST);
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                w_reg    <= cfg_clamped;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end

            if (accept)
            begin
                pend_reg <= result;
            end
            else if (out_free)
            begin
                pend_reg <= 1'b0;
            end

            if (out_free)
            begin
                out_valid_reg <= pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pend_reg)
        begin
            out_data_reg <= median;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

FILE: src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted sample row
// Holds one sample and its age. On each transfer the slot takes the value
// from its lower neighbor, from itself or its upper neighbor, or the new
// sample, so that the row stays sorted with the oldest sample removed.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swm_pkg::cell_ctl_t            ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] dn_value,
    input  logic                          dn_valid,
    input  logic [AGE_W-1:0]              dn_age,
    input  logic                          self_valid,
    input  logic signed [SAMPLE_BITS-1:0] up_value,
    input  logic                          up_valid,
    input  logic [AGE_W-1:0]              up_age,
    input  logic                          shift_prev,
    input  logic                          shift_here,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          valid,
    output logic [AGE_W-1:0]              age
);

    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [AGE_W-1:0]              age_reg;
    logic [AGE_W-1:0]              age_next;

    logic signed [SAMPLE_BITS-1:0] prv_value;
    logic                          prv_valid;
    logic [AGE_W-1:0]              prv_age;
    logic signed [SAMPLE_BITS-1:0] cur_value;
    logic                          cur_valid;
    logic [AGE_W-1:0]              cur_age;
    logic                          prv_gt;
    logic                          cur_gt;

    always_comb
    begin
        // entry below after removal of the oldest
        prv_value = shift_prev ? value_reg  : dn_value;
        prv_valid = shift_prev ? self_valid : dn_valid;
        prv_age   = shift_prev ? age_reg    : dn_age;
        // entry at this slot after removal of the oldest
        cur_value = shift_here ? up_value : value_reg;
        cur_valid = shift_here ? up_valid : self_valid;
        cur_age   = shift_here ? up_age   : age_reg;

        // empty slots count as above every sample
        prv_gt = !prv_valid || (prv_value > sample);
        cur_gt = !cur_valid || (cur_value > sample);

        if (prv_gt)
        begin
            value_next = prv_value;
            valid_next = prv_valid;
            age_next   = prv_age + AGE_W'(1);
        end
        else if (cur_gt)
        begin
            value_next = sample;
            valid_next = 1'b1;
            age_next   = '0;
        end
        else
        begin
            value_next = cur_value;
            valid_next = cur_valid;
            age_next   = cur_age + AGE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign age   = age_reg;

endmodule

FILE: src/swm_median.sv
// ----------------------------------------------------------------------------
// swm_median: middle pick from the sorted row
// Selects the two middle slots for the current window size and adds them,
// giving the median with one fraction bit.
// ----------------------------------------------------------------------------
module swm_median #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic signed [SAMPLE_BITS-1:0] values [MAX_WINDOW],
    input  logic [CNT_W-1:0]              window,
    output logic signed [SAMPLE_BITS:0]   median
);

    import swm_pkg::*;

    logic [CNT_W-1:0]              lo_full;
    logic [CNT_W-1:0]              hi_full;
    logic [AGE_W-1:0]              lo_idx;
    logic [AGE_W-1:0]              hi_idx;
    logic signed [SAMPLE_BITS-1:0] lo_value;
    logic signed [SAMPLE_BITS-1:0] hi_value;

    always_comb
    begin
        lo_full  = (window - CNT_W'(1)) >> 1;
        hi_full  = window >> 1;
        lo_idx   = lo_full[AGE_W-1:0];
        hi_idx   = hi_full[AGE_W-1:0];
        lo_value = values[lo_idx];
        hi_value = values[hi_idx];
        median   = {lo_value[SAMPLE_BITS-1], lo_value} + {hi_value[SAMPLE_BITS-1], hi_value};
    end

endmodule
